[rtl/core/dfiir_pkg.sv]
// Shared types and codes for the direct-form-I IIR filter.
package dfiir_pkg;

    // Width of the configuration register index and data.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_NUM_COEF = 2'd1,
        KIND_DEN_COEF = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUM_TAPS     = 2'd0,
        CFG_DEN_TAPS     = 2'd1,
        CFG_COMPLEX_MODE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_DEN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;  // start a new sum
        logic issue;  // multiply the operands offered this cycle
        logic sub;    // subtract this product instead of adding it
    } mac_ctl_t;

endpackage

[rtl/core/dfiir_if.sv]
// Channel interfaces of the IIR filter: sample/coefficient input, result, configuration.
interface dfiir_in_if #(
    parameter int COEF_BITS = 24
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic signed [15:0]          sample_re;
    logic signed [15:0]          sample_im;
    logic [2:0]                  coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic                        last_in;

    modport source (output valid, kind, sample_re, sample_im, coef_index, coef_value,
                    last_in, input ready);
    modport sink   (input valid, kind, sample_re, sample_im, coef_index, coef_value,
                    last_in, output ready);
endinterface

interface dfiir_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_re;
    logic signed [15:0] filtered_im;
    logic               saturated;
    logic               last_out;

    modport source (output valid, filtered_re, filtered_im, saturated, last_out,
                    input ready);
    modport sink   (input valid, filtered_re, filtered_im, saturated, last_out,
                    output ready);
endinterface

interface dfiir_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dfiir_pkg::CFG_INDEX_W-1:0]   index;
    logic [dfiir_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/dfiir_mac.sv]
// Dual-lane (real/imaginary) multiply-accumulate unit with rounding and saturation.
module dfiir_mac #(
    parameter int COEF_BITS = 24,
    parameter int TERMS     = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfiir_pkg::mac_ctl_t         ctl,
    input  logic signed [15:0]          data_re,
    input  logic signed [15:0]          data_im,
    input  logic signed [COEF_BITS-1:0] coef,
    output logic signed [15:0]          y_re,
    output logic signed [15:0]          y_im,
    output logic                        clip_re,
    output logic                        clip_im
);
    localparam int PROD_W = 16 + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TERMS + 1) + 1;
    localparam int FRAC   = COEF_BITS - 4;
    localparam int R_W    = ACC_W - FRAC;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC - 1);

    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic                     prod_valid_reg, prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]  rsum_re, rsum_im, rshift_re, rshift_im;
    logic signed [R_W-1:0]    r_re, r_im;

    // Product stage: one multiply per lane, registered
    always_ff @(posedge clk)
    begin
        prod_re_reg <= PROD_W'(data_re * coef);
        prod_im_reg <= PROD_W'(data_im * coef);
    end

    // Track which product is live and its sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.issue & ~ctl.clear;
            prod_sub_reg   <= ctl.sub;
        end
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            if (prod_sub_reg)
            begin
                acc_re_reg <= acc_re_reg - ACC_W'(prod_re_reg);
                acc_im_reg <= acc_im_reg - ACC_W'(prod_im_reg);
            end
            else
            begin
                acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
                acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
            end
        end
    end

    // Round half up to Q1.15
    always_comb
    begin
        rsum_re   = acc_re_reg + HALF_LSB;
        rsum_im   = acc_im_reg + HALF_LSB;
        rshift_re = rsum_re >>> FRAC;
        rshift_im = rsum_im >>> FRAC;
        r_re      = R_W'(rshift_re);
        r_im      = R_W'(rshift_im);
    end

    // Saturate: clip when the bits above the sign do not all match it
    always_comb
    begin
        clip_re = ~((&r_re[R_W-1:15]) | ~(|r_re[R_W-1:15]));
        clip_im = ~((&r_im[R_W-1:15]) | ~(|r_im[R_W-1:15]));
        y_re    = clip_re ? (r_re[R_W-1] ? 16'sh8000 : 16'sh7FFF) : r_re[15:0];
        y_im    = clip_im ? (r_im[R_W-1] ? 16'sh8000 : 16'sh7FFF) : r_im[15:0];
    end

endmodule

[rtl/core/direct_form_iir_filter_top.sv]
// Top level of the direct-form-I IIR filter: tables, delay lines, sequencer, result register.
//
// Channels: "item" takes a sample (kind 0) or a coefficient write into the numerator
// (kind 1) or denominator (kind 2) table; kind 3 is dropped. "result" gives one beat per
// sample; "cfg" writes num_taps, den_taps and complex_mode and is always ready.
// A coefficient write leaves the block ready for the next item. A sample walks the
// shared dual-lane MAC over nb numerator taps and then na-1 denominator taps (nb, na =
// tap counts clamped to 1..max), plus a drain step and a round/saturate step that
// loads the result register; no new item is taken until the sequencer is back in
// idle after that step.
// Real and imaginary parts run side by side in the two MAC lanes.
// The result sits in an output register; while the receiver stalls the block still
// takes the next item, and only the round/saturate step of the following sample
// waits for the register to free up.
// Reset clears the delay lines and coefficient tables, sets num_taps and den_taps
// to one and complex_mode to zero, and empties the result register.
// Configuration must be written only while no sample is in flight.
module direct_form_iir_filter_top #(
    parameter int MAX_NUM_TAPS = 8,
    parameter int MAX_DEN_TAPS = 8,
    parameter int COEF_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    dfiir_in_if.sink    item,
    dfiir_out_if.source result,
    dfiir_cfg_if.sink   cfg
);
    localparam int MAX_TAPS = (MAX_NUM_TAPS > MAX_DEN_TAPS) ? MAX_NUM_TAPS : MAX_DEN_TAPS;
    localparam int CNT_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NIDX_W   = (MAX_NUM_TAPS > 1) ? $clog2(MAX_NUM_TAPS) : 1;
    localparam int DIDX_W   = (MAX_DEN_TAPS > 1) ? $clog2(MAX_DEN_TAPS) : 1;

    // Configuration registers
    logic [3:0] num_taps_reg, den_taps_reg;
    logic       complex_mode_reg;

    // Tables and delay lines
    logic signed [COEF_BITS-1:0] num_coef_reg [MAX_NUM_TAPS];
    logic signed [COEF_BITS-1:0] den_coef_reg [MAX_DEN_TAPS];
    logic signed [15:0]          xd_re_reg    [MAX_NUM_TAPS];
    logic signed [15:0]          xd_im_reg    [MAX_NUM_TAPS];
    logic signed [15:0]          yd_re_reg    [MAX_DEN_TAPS];
    logic signed [15:0]          yd_im_reg    [MAX_DEN_TAPS];

    // Sequencer
    dfiir_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]    tap_reg, tap_next;
    logic [CNT_W-1:0]    num_last, den_last;
    logic                last_reg;
    dfiir_pkg::mac_ctl_t mac_ctl;
    logic                item_accept, sample_accept, out_load;

    // Operands and MAC results
    logic signed [15:0]          op_re, op_im;
    logic signed [COEF_BITS-1:0] op_coef;
    logic signed [15:0]          y_re, y_im;
    logic                        clip_re, clip_im;

    // Result register
    logic               out_valid_reg;
    logic signed [15:0] out_re_reg, out_im_reg;
    logic               out_sat_reg, out_last_reg;

    assign item_accept   = item.valid & item.ready;
    assign sample_accept = item_accept & (item.kind == dfiir_pkg::KIND_SAMPLE);
    assign cfg.ready     = 1'b1;

    // Clamp tap counts to 1..max and form the index of the last tap
    always_comb
    begin
        if (num_taps_reg == 4'd0)
            num_last = '0;
        else if (32'(num_taps_reg) > MAX_NUM_TAPS)
            num_last = CNT_W'(MAX_NUM_TAPS - 1);
        else
            num_last = CNT_W'(num_taps_reg - 4'd1);

        if (den_taps_reg == 4'd0)
            den_last = '0;
        else if (32'(den_taps_reg) > MAX_DEN_TAPS)
            den_last = CNT_W'(MAX_DEN_TAPS - 1);
        else
            den_last = CNT_W'(den_taps_reg - 4'd1);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg     <= 4'd1;
            den_taps_reg     <= 4'd1;
            complex_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (dfiir_pkg::cfg_index_t'(cfg.index))
                dfiir_pkg::CFG_NUM_TAPS:     num_taps_reg     <= cfg.data;
                dfiir_pkg::CFG_DEN_TAPS:     den_taps_reg     <= cfg.data;
                dfiir_pkg::CFG_COMPLEX_MODE: complex_mode_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Coefficient writes; indexes beyond the tables are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NUM_TAPS; i++)
                num_coef_reg[i] <= '0;
            for (int i = 0; i < MAX_DEN_TAPS; i++)
                den_coef_reg[i] <= '0;
        end
        else if (item_accept)
        begin
            if (item.kind == dfiir_pkg::KIND_NUM_COEF && 32'(item.coef_index) < MAX_NUM_TAPS)
                num_coef_reg[NIDX_W'(item.coef_index)] <= item.coef_value;
            if (item.kind == dfiir_pkg::KIND_DEN_COEF && 32'(item.coef_index) < MAX_DEN_TAPS)
                den_coef_reg[DIDX_W'(item.coef_index)] <= item.coef_value;
        end
    end

    // Input delay lines: shift in the new sample (zero imaginary in real mode)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NUM_TAPS; i++)
            begin
                xd_re_reg[i] <= '0;
                xd_im_reg[i] <= '0;
            end
        end
        else if (sample_accept)
        begin
            xd_re_reg[0] <= item.sample_re;
            xd_im_reg[0] <= complex_mode_reg ? item.sample_im : 16'sd0;
            for (int i = 1; i < MAX_NUM_TAPS; i++)
            begin
                xd_re_reg[i] <= xd_re_reg[i-1];
                xd_im_reg[i] <= xd_im_reg[i-1];
            end
        end
    end

    // Output delay lines: shift in the saturated result; entry zero stays unused
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DEN_TAPS; i++)
            begin
                yd_re_reg[i] <= '0;
                yd_im_reg[i] <= '0;
            end
        end
        else if (out_load)
        begin
            for (int i = 1; i < MAX_DEN_TAPS; i++)
            begin
                yd_re_reg[i] <= (i == 1) ? y_re : yd_re_reg[i-1];
                yd_im_reg[i] <= (i == 1) ? y_im : yd_im_reg[i-1];
            end
        end
    end

    // Hold the end-of-buffer mark for the sample in flight
    always_ff @(posedge clk)
    begin
        if (sample_accept)
            last_reg <= item.last_in;
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfiir_pkg::ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfiir_pkg::ST_IDLE:
                if (sample_accept)
                    state_next = dfiir_pkg::ST_NUM;
            dfiir_pkg::ST_NUM:
                if (tap_reg == num_last)
                    state_next = (den_last != '0) ? dfiir_pkg::ST_DEN : dfiir_pkg::ST_DRAIN;
            dfiir_pkg::ST_DEN:
                if (tap_reg == den_last)
                    state_next = dfiir_pkg::ST_DRAIN;
            dfiir_pkg::ST_DRAIN:
                state_next = dfiir_pkg::ST_FINISH;
            dfiir_pkg::ST_FINISH:
                if (out_load)
                    state_next = dfiir_pkg::ST_IDLE;
            default:
                state_next = dfiir_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, tap counter, MAC control
    always_comb
    begin
        item.ready    = 1'b0;
        tap_next      = tap_reg;
        mac_ctl.clear = 1'b0;
        mac_ctl.issue = 1'b0;
        mac_ctl.sub   = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            dfiir_pkg::ST_IDLE:
            begin
                item.ready    = 1'b1;
                mac_ctl.clear = item.valid & (item.kind == dfiir_pkg::KIND_SAMPLE);
                tap_next      = '0;
            end
            dfiir_pkg::ST_NUM:
            begin
                mac_ctl.issue = 1'b1;
                tap_next      = (tap_reg == num_last) ? CNT_W'(1) : tap_reg + CNT_W'(1);
            end
            dfiir_pkg::ST_DEN:
            begin
                mac_ctl.issue = 1'b1;
                mac_ctl.sub   = 1'b1;
                tap_next      = tap_reg + CNT_W'(1);
            end
            dfiir_pkg::ST_DRAIN: ;
            dfiir_pkg::ST_FINISH:
                out_load = ~out_valid_reg | result.ready;
            default: ;
        endcase
    end

    // Operand select for the current tap
    always_comb
    begin
        if (state_reg == dfiir_pkg::ST_DEN)
        begin
            op_re   = yd_re_reg[DIDX_W'(tap_reg)];
            op_im   = yd_im_reg[DIDX_W'(tap_reg)];
            op_coef = den_coef_reg[DIDX_W'(tap_reg)];
        end
        else
        begin
            op_re   = xd_re_reg[NIDX_W'(tap_reg)];
            op_im   = xd_im_reg[NIDX_W'(tap_reg)];
            op_coef = num_coef_reg[NIDX_W'(tap_reg)];
        end
    end

    dfiir_mac #(
        .COEF_BITS (COEF_BITS),
        .TERMS     (MAX_NUM_TAPS + MAX_DEN_TAPS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .data_re (op_re),
        .data_im (op_im),
        .coef    (op_coef),
        .y_re    (y_re),
        .y_im    (y_im),
        .clip_re (clip_re),
        .clip_im (clip_im)
    );

    // Result register: load a finished sample, drop the beat once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg   <= y_re;
            out_im_reg   <= complex_mode_reg ? y_im : 16'sd0;
            out_sat_reg  <= clip_re | (complex_mode_reg & clip_im);
            out_last_reg <= last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.filtered_re = out_re_reg;
    assign result.filtered_im = out_im_reg;
    assign result.saturated   = out_sat_reg;
    assign result.last_out    = out_last_reg;

    // A sample beat always starts the numerator walk
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> state_reg == dfiir_pkg::ST_NUM && tap_reg == '0)
        else $error("sample beat did not start numerator walk");

    // The denominator walk never touches entry zero
    a_den_skips_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dfiir_pkg::ST_DEN |-> tap_reg != '0 && tap_reg <= den_last)
        else $error("denominator tap out of range");

    // The numerator walk stays within the taps in use
    a_num_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dfiir_pkg::ST_NUM |-> tap_reg <= num_last)
        else $error("numerator tap out of range");

    // A finished sample always lands in the result register
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == dfiir_pkg::ST_IDLE)
        else $error("finished sample not presented");

endmodule

[dv/tb_top.sv]
// Testbench for the direct-form-I IIR filter: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD      = 4;
    localparam int TAPS            = 8;
    localparam int COEF_FRAC       = 20;
    localparam int ITEM_TARGET     = 1600;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        dfiir_pkg::kind_t   kind;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [2:0]         idx;
        logic signed [23:0] coef;
        logic               last;
    } filt_item_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               sat;
        logic               last;
    } filt_out_t;

    typedef struct {
        filt_item_t it;
        bit         known;
        filt_out_t  want;
    } dir_row_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    dfiir_in_if #(.COEF_BITS(24)) item_ch ();
    dfiir_out_if                  result_ch ();
    dfiir_cfg_if                  cfg_ch ();

    direct_form_iir_filter_top #(
        .MAX_NUM_TAPS (TAPS),
        .MAX_DEN_TAPS (TAPS),
        .COEF_BITS    (24)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Filter state as the block should hold it; lane 0 real, lane 1 imaginary
    logic signed [15:0] x_hist [2][TAPS];
    logic signed [15:0] y_hist [2][TAPS];
    logic signed [23:0] b_coef [TAPS];
    logic signed [23:0] a_coef [TAPS];
    logic [3:0]         num_taps_q;
    logic [3:0]         den_taps_q;
    logic               cmplx_q;

    filt_out_t pending_outputs [$];

    int  n_samples, n_coef_writes, n_ignored, n_reg_writes, n_settings;
    int  n_results, n_saturated, n_complex, n_errors;
    int  idle_cycles;
    int  burst_left;
    bit  no_gaps;
    bit  pressure_done;

    function automatic int clamp_taps(logic [3:0] t);
        if (t == 4'd0)
            return 1;
        if (int'(t) > TAPS)
            return TAPS;
        return int'(t);
    endfunction

    // Shift one lane, accumulate, round half up, saturate, feed back
    function automatic logic signed [15:0] filter_lane(int lane, logic signed [15:0] xin,
                                                        int nb, int na, output logic clip);
        longint             acc;
        longint             r;
        logic signed [15:0] y;
        for (int i = TAPS - 1; i >= 1; i--)
            x_hist[lane][i] = x_hist[lane][i - 1];
        x_hist[lane][0] = xin;
        acc = 0;
        for (int i = 0; i < nb; i++)
            acc += longint'(x_hist[lane][i]) * longint'(b_coef[i]);
        for (int i = 1; i < na; i++)
            acc -= longint'(y_hist[lane][i]) * longint'(a_coef[i]);
        r = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        clip = 1'b0;
        if (r > 32767) begin
            clip = 1'b1;
            y = 16'sh7FFF;
        end else if (r < -32768) begin
            clip = 1'b1;
            y = 16'sh8000;
        end else begin
            y = r[15:0];
        end
        for (int i = TAPS - 1; i >= 2; i--)
            y_hist[lane][i] = y_hist[lane][i - 1];
        y_hist[lane][1] = y;
        return y;
    endfunction

    function automatic filt_out_t filter_sample(filt_item_t it);
        filt_out_t          o;
        logic               clip_re;
        logic               clip_im;
        logic signed [15:0] im_out;
        int                 nb;
        int                 na;
        nb = clamp_taps(num_taps_q);
        na = clamp_taps(den_taps_q);
        o.re = filter_lane(0, it.re, nb, na, clip_re);
        // real mode still runs the imaginary lane on zero input
        im_out = filter_lane(1, cmplx_q ? it.im : 16'sd0, nb, na, clip_im);
        o.im   = cmplx_q ? im_out : 16'sd0;
        o.sat  = clip_re | (cmplx_q & clip_im);
        o.last = it.last;
        return o;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    // Gentle values keep the feedback stable; full range exercises every bit
    function automatic logic signed [23:0] pick_coef(bit full, bit den);
        if (full)
            return 24'($urandom);
        if (den)
            return 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        return 24'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic dir_row_t mkrow(dfiir_pkg::kind_t k, int re, int im, int idx, int coef,
                                       bit last, bit known, int want_re, bit want_sat);
        dir_row_t r;
        r.it.kind   = k;
        r.it.re     = re[15:0];
        r.it.im     = im[15:0];
        r.it.idx    = idx[2:0];
        r.it.coef   = coef[23:0];
        r.it.last   = last;
        r.known     = known;
        r.want.re   = want_re[15:0];
        r.want.im   = 16'sd0;
        r.want.sat  = want_sat;
        r.want.last = last;
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then update the filter state
    task automatic drive_item(filt_item_t it, bit known, filt_out_t typed);
        filt_out_t want;
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= it.kind;
        item_ch.sample_re  <= it.re;
        item_ch.sample_im  <= it.im;
        item_ch.coef_index <= it.idx;
        item_ch.coef_value <= it.coef;
        item_ch.last_in    <= it.last;
        do @(posedge clk); while (!item_ch.ready);
        case (it.kind)
            dfiir_pkg::KIND_SAMPLE: begin
                want = filter_sample(it);
                pending_outputs.push_back(known ? typed : want);
                n_samples++;
                if (cmplx_q)
                    n_complex++;
            end
            dfiir_pkg::KIND_NUM_COEF: begin
                b_coef[it.idx] = it.coef;
                n_coef_writes++;
            end
            dfiir_pkg::KIND_DEN_COEF: begin
                a_coef[it.idx] = it.coef;
                n_coef_writes++;
            end
            default: n_ignored++;
        endcase
    endtask

    // Burst of beats, then a random gap; some phases run with no gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(dfiir_pkg::cfg_index_t idx, logic [3:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            dfiir_pkg::CFG_NUM_TAPS:     num_taps_q = val;
            dfiir_pkg::CFG_DEN_TAPS:     den_taps_q = val;
            dfiir_pkg::CFG_COMPLEX_MODE: cmplx_q = val[0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // Drain every outstanding result, then let a trailing coefficient write settle
    task automatic wait_quiet();
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus: directed table, then random phases under changing settings
    initial begin : stimulus
        dir_row_t   dir_rows [$];
        filt_item_t it;
        filt_out_t  no_want;
        logic [3:0] n_cfg;
        logic [3:0] d_cfg;
        logic       c_cfg;
        bit         full_range;
        int         phase;
        int         pick;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= dfiir_pkg::KIND_SAMPLE;
        item_ch.sample_re  <= '0;
        item_ch.sample_im  <= '0;
        item_ch.coef_index <= '0;
        item_ch.coef_value <= '0;
        item_ch.last_in    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= dfiir_pkg::CFG_NUM_TAPS;
        cfg_ch.data        <= '0;

        for (int i = 0; i < TAPS; i++) begin
            b_coef[i] = '0;
            a_coef[i] = '0;
            for (int l = 0; l < 2; l++) begin
                x_hist[l][i] = '0;
                y_hist[l][i] = '0;
            end
        end
        num_taps_q = 4'd1;
        den_taps_q = 4'd1;
        cmplx_q    = 1'b0;
        no_want    = '{default: '0};
        burst_left = 0;
        no_gaps    = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: one tap each, real mode, tables clear after reset
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 32767, -32768, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NONE, -1, -1, 7, -1, 1, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 0, 1048576, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 32767, 5, 0, 0, 0, 1, 32767, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, -32768, 32767, 0, 0, 1, 1, -32768, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 0, 524288, 0, 0, 0, 0));
        // half-way cases round up
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 1, 0, 0, 0, 0, 1, 1, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, -1, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 3, 0, 0, 0, 1, 1, 2, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, -3, 0, 0, 0, 0, 1, -1, 0));
        // largest coefficients clip both ways
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 0, 8388607, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 32767, 0, 0, 0, 0, 1, 32767, 1));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, -32768, 0, 0, 0, 1, 1, -32768, 1));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 0, -8388608, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, -32768, 0, 0, 0, 0, 1, 32767, 1));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 1, 0, 0, 0, 0, 1, -8, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 0, 0, 0, 0, 1, 1, 0, 0));
        // top table slots and the unused denominator entry zero
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 7, 8388607, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_DEN_COEF, 0, 0, 0, -8388608, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_DEN_COEF, 0, 0, 7, 8388607, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_DEN_COEF, 0, 0, 1, -1, 1, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NUM_COEF, 0, 0, 0, 1048576, 0, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_SAMPLE, 12345, -999, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mkrow(dfiir_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0));

        foreach (dir_rows[r]) begin
            drive_item(dir_rows[r].it, dir_rows[r].known, dir_rows[r].want);
            pace_sender();
        end
        item_ch.valid <= 1'b0;
        wait_quiet();

        phase = 0;
        while (n_samples + n_coef_writes < ITEM_TARGET) begin
            // Pick settings: extremes first, then random
            case (phase)
                0:       {n_cfg, d_cfg, c_cfg} = {4'd8,  4'd8,  1'b1};
                1:       {n_cfg, d_cfg, c_cfg} = {4'd1,  4'd1,  1'b1};
                2:       {n_cfg, d_cfg, c_cfg} = {4'd8,  4'd1,  1'b0};
                3:       {n_cfg, d_cfg, c_cfg} = {4'd1,  4'd8,  1'b1};
                4:       {n_cfg, d_cfg, c_cfg} = {4'd0,  4'd0,  1'b0};
                5:       {n_cfg, d_cfg, c_cfg} = {4'd15, 4'd15, 1'b1};
                6:       {n_cfg, d_cfg, c_cfg} = {4'd9,  4'd3,  1'b0};
                default: begin
                    n_cfg = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    d_cfg = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
                    c_cfg = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(dfiir_pkg::CFG_NUM_TAPS, n_cfg);
            write_reg(dfiir_pkg::CFG_DEN_TAPS, d_cfg);
            write_reg(dfiir_pkg::CFG_COMPLEX_MODE, {3'($urandom), c_cfg});
            if (phase % 3 == 0)
                write_reg(dfiir_pkg::CFG_UNUSED, 4'($urandom));
            cfg_ch.valid <= 1'b0;
            n_settings++;

            full_range = ($urandom_range(0, 4) == 0);
            no_gaps    = ($urandom_range(0, 3) == 0);

            // Load both tables in full
            for (int k = 0; k < 2 * TAPS; k++) begin
                it.kind = (k < TAPS) ? dfiir_pkg::KIND_NUM_COEF : dfiir_pkg::KIND_DEN_COEF;
                it.idx  = k[2:0];
                it.coef = pick_coef(full_range, k >= TAPS);
                it.re   = 16'($urandom);
                it.im   = 16'($urandom);
                it.last = 1'($urandom_range(0, 1));
                drive_item(it, 1'b0, no_want);
                pace_sender();
            end

            // Mostly samples, with stray coefficient updates and dropped kinds
            repeat ($urandom_range(40, 100)) begin
                pick    = $urandom_range(0, 99);
                it.re   = pick_sample();
                it.im   = pick_sample();
                it.idx  = 3'($urandom);
                it.last = ($urandom_range(0, 7) == 0);
                if (pick < 86)
                    it.kind = dfiir_pkg::KIND_SAMPLE;
                else if (pick < 94)
                    it.kind = pick[0] ? dfiir_pkg::KIND_NUM_COEF : dfiir_pkg::KIND_DEN_COEF;
                else
                    it.kind = dfiir_pkg::KIND_NONE;
                it.coef = pick_coef(full_range || $urandom_range(0, 9) == 0,
                                    it.kind == dfiir_pkg::KIND_DEN_COEF);
                drive_item(it, 1'b0, no_want);
                pace_sender();
            end
            item_ch.valid <= 1'b0;
            wait_quiet();
            phase++;
        end

        $display("Checked %0d results from %0d samples (%0d complex, %0d clipped).",
                 n_results, n_samples, n_complex, n_saturated);
        $display("Also %0d coefficient writes, %0d dropped items, %0d register writes, %0d settings.",
                 n_coef_writes, n_ignored, n_reg_writes, n_settings);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result ready: random stretches of patterns, plus one long hold-off
    initial begin : result_pacer
        rx_mode_t mode;
        int       stretch_left;
        int       stall_left;
        int       tick;
        result_ch.ready <= 1'b0;
        mode          = RX_OPEN;
        stretch_left  = 0;
        stall_left    = 0;
        tick          = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (stretch_left == 0) begin
                mode         = rx_mode_t'($urandom_range(0, 3));
                stretch_left = $urandom_range(20, 150);
            end
            stretch_left--;
            if (!pressure_done && n_samples >= HOLD_OFF_AT) begin
                pressure_done = 1'b1;
                stall_left    = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_ch.ready <= (tick % 4 == 0);
                    default:   result_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin : output_check
        filt_out_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            n_results++;
            if (pending_outputs.size() == 0) begin
                n_errors++;
                $display("%0t ns: result beat with nothing expected, actual re=%0d im=%0d",
                         $time, result_ch.filtered_re, result_ch.filtered_im);
            end else begin
                want = pending_outputs.pop_front();
                if (want.sat)
                    n_saturated++;
                if (result_ch.filtered_re !== want.re || result_ch.filtered_im !== want.im ||
                    result_ch.saturated !== want.sat || result_ch.last_out !== want.last) begin
                    n_errors++;
                    $display({"%0t ns: result %0d mismatch: expected re=%0d im=%0d sat=%0b ",
                              "last=%0b, actual re=%0d im=%0d sat=%0b last=%0b"},
                             $time, n_results, want.re, want.im, want.sat, want.last,
                             result_ch.filtered_re, result_ch.filtered_im,
                             result_ch.saturated, result_ch.last_out);
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no beat on any channel for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_outputs.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

[direct_form_iir_filter_top.f]
rtl/core/dfiir_pkg.sv
rtl/core/dfiir_if.sv
rtl/core/dfiir_mac.sv
rtl/core/direct_form_iir_filter_top.sv
dv/tb_top.sv
